[sv/cdc_pkg.sv]
// Shared types and constants for the card-key door controller.
package cdc_pkg;

  localparam int unsigned TIME_BITS  = 16;
  localparam int unsigned TIMER_W    = TIME_BITS + 1;
  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned KEY_IDX_W  = $clog2(KEY_BITS);
  localparam int unsigned ELAPSED_W  = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = TIME_BITS;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 24;

  // Configuration register reset values
  localparam logic [TIME_BITS-1:0] HOLD_OPEN_RST  = 16'd3000;
  localparam logic [TIME_BITS-1:0] TRAVEL_RST     = 16'd1000;
  localparam logic [TIME_BITS-1:0] CARD_CHECK_RST = 16'd2000;
  localparam logic [TIME_BITS-1:0] ERROR_SHOW_RST = 16'd3000;
  localparam logic [KEY_IDX_W-1:0] KEY_INDEX_RST  = '0;

  localparam logic [7:0] OCC_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD_OPEN  = 3'd0,
    CFG_TRAVEL     = 3'd1,
    CFG_CARD_CHECK = 3'd2,
    CFG_ERROR_SHOW = 3'd3,
    CFG_KEY_INDEX  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_CARD  = 2'd1,
    MODE_ENTER = 2'd2,
    MODE_LEAVE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    PH_CLOSED  = 3'd0,
    PH_READING = 3'd1,
    PH_ERROR   = 3'd2,
    PH_OPENING = 3'd3,
    PH_OPEN    = 3'd4,
    PH_CLOSING = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    LT_STANDBY = 2'd0,
    LT_READING = 2'd1,
    LT_GRANTED = 2'd2,
    LT_DENIED  = 2'd3
  } light_e;

  typedef enum logic [2:0] {
    NT_NONE     = 3'd0,
    NT_CARD     = 3'd1,
    NT_GRANTED  = 3'd2,
    NT_DENIED   = 3'd3,
    NT_CLOSING  = 3'd4
  } notice_e;

  typedef struct packed {
    notice_e              notice;
    light_e               indicator;
    logic [TIME_BITS-1:0] travel_progress;
    phase_e               door_phase;
  } result_t;

endpackage

[sv/cardkey_door_controller.sv]
// Card-key sliding door controller: state update, output register and skid stage.
//
// Usage:
//  - Input stream (s_axis_*): one item per transfer. tuser carries the item kind
//    (tick, card presented, body enters, body leaves); tdata carries the tick's
//    elapsed time, the alert lever level and the presenter's key mask.
//  - Output stream (m_axis_*): exactly one result per input item, in order:
//    door phase, travel progress, indicator light and the event of that item.
//  - Configuration: write cfg_wdata_i into register cfg_idx_i on a cycle with
//    cfg_we_i high; write only while no item is in flight. Indexes beyond the
//    register list are ignored.
//  - Result path: an item's result is registered, in the skid register if the output register is full.
//  - Throughput: one item per cycle while s_axis_tready is high. The whole per-item
//    update is one pass of combinational logic from the door state registers and
//    the input bus into the state and result registers.
//  - Stall: a skid register behind the output register holds one more result,
//    so an item is taken while a result waits; s_axis_tready drops only when
//    both are full and rises again once the receiver takes a result.
//  - Reset (rst_ni low): door closed, shut, light standby, timers and counts
//    cleared, alert unlatched, configuration at its defaults, output empty.
module cardkey_door_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [cdc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cdc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // Input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: elapsed[11:0], alert_lever[12], held_keys[44:13], zero pad[47:45]
  input  logic [cdc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: mode[1:0]
  input  logic [cdc_pkg::IN_USER_W-1:0]    s_axis_tuser,
  // Output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: door_phase[2:0], travel_progress[18:3], indicator[20:19], notice[23:21]
  output logic [cdc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  import cdc_pkg::*;

  // Configuration registers
  logic [TIME_BITS-1:0] hold_open_q, travel_q, card_check_q, error_show_q;
  logic [KEY_IDX_W-1:0] key_index_q;

  // Door state
  phase_e               phase_q, phase_d;
  light_e               light_q, light_d;
  logic [TIMER_W-1:0]   phase_timer_q, phase_timer_d;
  logic [TIMER_W-1:0]   open_timer_q, open_timer_d;
  logic [TIME_BITS-1:0] progress_q, progress_d;
  logic                 alert_q, alert_d;
  logic [7:0]           occ_count_q, occ_count_d;
  logic                 occupied_q, occupied_d;
  notice_e              notice;

  // Output and skid registers
  result_t              out_q, skid_q, result;
  logic                 out_valid_q, skid_valid_q;

  // Input field unpacking
  mode_e                mode;
  logic [ELAPSED_W-1:0] elapsed;
  logic                 lever;
  logic [KEY_BITS-1:0]  held_keys;
  logic                 in_xfer, out_xfer;

  // Arithmetic helpers
  logic [TIMER_W:0]     pt_sum, ot_sum;
  logic [TIMER_W-1:0]   pt_sat, ot_sat;
  logic [TIME_BITS:0]   prog_sum;
  logic [TIME_BITS-1:0] elapsed_ext;

  assign mode      = mode_e'(s_axis_tuser[1:0]);
  assign elapsed   = s_axis_tdata[ELAPSED_W-1:0];
  assign lever     = s_axis_tdata[ELAPSED_W];
  assign held_keys = s_axis_tdata[ELAPSED_W+1 +: KEY_BITS];

  assign s_axis_tready = !skid_valid_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = out_valid_q && m_axis_tready;

  // Saturating timer sums and travel sum
  assign elapsed_ext = TIME_BITS'(elapsed);
  assign pt_sum   = (TIMER_W+1)'(phase_timer_q) + (TIMER_W+1)'(elapsed);
  assign ot_sum   = (TIMER_W+1)'(open_timer_q) + (TIMER_W+1)'(elapsed);
  assign pt_sat   = pt_sum[TIMER_W] ? TIMER_MAX : pt_sum[TIMER_W-1:0];
  assign ot_sat   = ot_sum[TIMER_W] ? TIMER_MAX : ot_sum[TIMER_W-1:0];
  assign prog_sum = (TIME_BITS+1)'(progress_q) + (TIME_BITS+1)'(elapsed);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_open_q  <= HOLD_OPEN_RST;
      travel_q     <= TRAVEL_RST;
      card_check_q <= CARD_CHECK_RST;
      error_show_q <= ERROR_SHOW_RST;
      key_index_q  <= KEY_INDEX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HOLD_OPEN:  hold_open_q  <= cfg_wdata_i;
        CFG_TRAVEL:     travel_q     <= cfg_wdata_i;
        CFG_CARD_CHECK: card_check_q <= cfg_wdata_i;
        CFG_ERROR_SHOW: error_show_q <= cfg_wdata_i;
        CFG_KEY_INDEX:  key_index_q  <= cfg_wdata_i[KEY_IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Next door state for the item on the input bus
  always_comb begin
    phase_d       = phase_q;
    light_d       = light_q;
    phase_timer_d = phase_timer_q;
    open_timer_d  = open_timer_q;
    progress_d    = progress_q;
    alert_d       = alert_q;
    occ_count_d   = occ_count_q;
    occupied_d    = occupied_q;
    notice        = NT_NONE;

    if (in_xfer) begin
      unique case (mode)
        MODE_TICK: begin
          // Latch the alert lever and force the door open
          if (!alert_q && lever) begin
            alert_d = 1'b1;
            phase_d = PH_OPENING;
          end
          // Phase decision
          unique case (phase_d)
            PH_READING: begin
              phase_timer_d = pt_sat;
              if (pt_sat >= TIMER_W'(card_check_q)) begin
                phase_timer_d = '0;
                if (held_keys[key_index_q]) begin
                  light_d = LT_GRANTED;
                  phase_d = PH_OPENING;
                  notice  = NT_GRANTED;
                end else begin
                  light_d = LT_DENIED;
                  phase_d = PH_ERROR;
                  notice  = NT_DENIED;
                end
              end
            end
            PH_ERROR: begin
              phase_timer_d = pt_sat;
              if (pt_sat >= TIMER_W'(error_show_q)) begin
                phase_timer_d = '0;
                light_d       = LT_STANDBY;
                phase_d       = PH_CLOSED;
              end
            end
            PH_OPEN: begin
              if (!alert_d) begin
                open_timer_d = ot_sat;
                if (ot_sat > TIMER_W'(hold_open_q)) begin
                  if (occupied_q) begin
                    open_timer_d = '0;
                  end else begin
                    light_d = LT_STANDBY;
                    phase_d = PH_CLOSING;
                    notice  = NT_CLOSING;
                  end
                end
              end
            end
            PH_CLOSING: begin
              if (occupied_q) phase_d = PH_OPENING;
              if (progress_q == '0) phase_d = PH_CLOSED;
            end
            PH_OPENING: begin
              if (progress_q >= travel_q) phase_d = PH_OPEN;
            end
            default: ;
          endcase
          // Door travel
          if (phase_d == PH_CLOSING) begin
            open_timer_d = '0;
            progress_d   = (progress_q > elapsed_ext) ? progress_q - elapsed_ext : '0;
          end else if (phase_d == PH_OPENING) begin
            progress_d = (prog_sum > (TIME_BITS+1)'(travel_q)) ? travel_q
                                                                : prog_sum[TIME_BITS-1:0];
          end
        end
        MODE_CARD: begin
          if (phase_q == PH_CLOSED) begin
            light_d = LT_READING;
            phase_d = PH_READING;
            notice  = NT_CARD;
          end
        end
        MODE_ENTER: begin
          if (occ_count_q != OCC_MAX) occ_count_d = occ_count_q + 8'd1;
          occupied_d = 1'b1;
        end
        MODE_LEAVE: begin
          if (occ_count_q != '0) occ_count_d = occ_count_q - 8'd1;
          if (occ_count_d == '0) occupied_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Door state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_CLOSED;
      light_q       <= LT_STANDBY;
      phase_timer_q <= '0;
      open_timer_q  <= '0;
      progress_q    <= '0;
      alert_q       <= 1'b0;
      occ_count_q   <= '0;
      occupied_q    <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      light_q       <= light_d;
      phase_timer_q <= phase_timer_d;
      open_timer_q  <= open_timer_d;
      progress_q    <= progress_d;
      alert_q       <= alert_d;
      occ_count_q   <= occ_count_d;
      occupied_q    <= occupied_d;
    end
  end

  // Result of this item: state after the update
  always_comb begin
    result.door_phase      = phase_d;
    result.travel_progress = progress_d;
    result.indicator       = light_d;
    result.notice          = notice;
  end

  // Output register with skid stage: valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_xfer) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_xfer;
      end
    end else if (in_xfer) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Output register with skid stage: payload
  always_ff @(posedge clk_i) begin
    if (out_xfer) begin
      out_q <= skid_valid_q ? skid_q : result;
    end else if (in_xfer) begin
      if (out_valid_q) begin
        skid_q <= result;
      end else begin
        out_q <= result;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_q);

  // Skid stage only fills behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register valid while output register empty");

  // Alert latch never releases
  a_alert_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alert_q |=> alert_q)
    else $error("alert latch released");

  // A stalled result is not dropped
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> out_valid_q)
    else $error("stalled result lost");

endmodule
